### src/dsbb_pkg.sv
// Shared types and constants for the dual sample block buffer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dsbb_pkg;

    // Defaults for the top-level parameters
    localparam int RING_DEPTH_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Fixed field widths of the ports
    localparam int VALUE_W = 16;
    localparam int LEN_W   = 7;

    // Opcodes of an input transaction
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Configuration register indexes
    localparam logic CFG_NOTIFY_ENABLE = 1'b0;
    localparam logic CFG_BLOCK_SIZE    = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic               channel;
        logic [VALUE_W-1:0] sample_value;
    } t_in;

    typedef struct packed {
        logic               out_channel;
        logic [VALUE_W-1:0] out_sample;
        logic [LEN_W-1:0]   block_length;
        logic               last;
    } t_out;

    typedef struct packed {
        logic             notify_enable;
        logic [LEN_W-1:0] block_size;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic {
        BK_IDLE,
        BK_DRAIN
    } t_back_state;

endpackage

`default_nettype wire

### src/dsbb_queue.sv
// Small command FIFO between the front and back of the block buffer.
// Depends on dsbb_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module dsbb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic [WIDTH-1:0]      i_push_data,
    input  wire logic                  i_pop,
    output logic [WIDTH-1:0]           o_pop_data,
    output dsbb_pkg::t_q_status        o_status
);
    import dsbb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;

    always_comb begin
        n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_push_data;
        end
    end

    assign o_pop_data     = r_slot[r_rd];
    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

`default_nettype wire

### src/dsbb_front.sv
// Front end: takes input transactions, keeps ring pointers and fill counts,
// and turns each store into a command for the back end. Depends on dsbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsbb_front #(
    parameter  int RING_DEPTH  = dsbb_pkg::RING_DEPTH_DEF,
    parameter  int SAMPLE_BITS = dsbb_pkg::SAMPLE_BITS_DEF,
    localparam int PTR_W       = $clog2(RING_DEPTH),
    localparam int CNT_W       = $clog2(RING_DEPTH + 1),
    localparam int CMD_W       = 2 + 2 * PTR_W + SAMPLE_BITS + CNT_W
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dsbb_pkg::t_cfg       i_cfg,
    input  wire logic                 i_in_valid,
    input  wire dsbb_pkg::t_in        i_in_data,
    output logic                      o_in_stall,
    output logic                      o_push,
    output logic [CMD_W-1:0]          o_cmd,
    input  wire dsbb_pkg::t_q_status  i_q_status
);
    import dsbb_pkg::*;

    typedef struct packed {
        logic                   ch;
        logic [PTR_W-1:0]       wptr;
        logic [SAMPLE_BITS-1:0] data;
        logic                   drain;
        logic [PTR_W-1:0]       rptr;
        logic [CNT_W-1:0]       len;
    } t_cmd;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [PTR_W-1:0] r_wp  [2];
    logic [PTR_W-1:0] r_rp  [2];
    logic [CNT_W-1:0] r_cnt [2];

    logic             w_accept;
    logic             w_ch;
    logic             w_full;
    logic             w_drain;
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] w_rp_start;
    logic [CNT_W-1:0] w_cnt_inc;
    t_cmd             w_cmd;

    assign o_in_stall = i_q_status.full;
    assign w_accept   = i_in_valid && !i_q_status.full;
    assign w_ch       = i_in_data.channel;

    always_comb begin
        w_full     = (r_cnt[w_ch] == CNT_W'(RING_DEPTH));
        n_wp       = ptr_next(r_wp[w_ch]);
        // A full ring drops its oldest sample, so the head moves with the tail
        w_rp_start = w_full ? ptr_next(r_rp[w_ch]) : r_rp[w_ch];
        w_cnt_inc  = w_full ? r_cnt[w_ch] : r_cnt[w_ch] + 1'b1;
        w_drain    = i_cfg.notify_enable && (LEN_W'(w_cnt_inc) >= i_cfg.block_size);

        w_cmd.ch    = w_ch;
        w_cmd.wptr  = r_wp[w_ch];
        w_cmd.data  = SAMPLE_BITS'(i_in_data.sample_value);
        w_cmd.drain = w_drain;
        w_cmd.rptr  = w_rp_start;
        w_cmd.len   = w_cnt_inc;
    end

    assign o_push = w_accept && (i_in_data.opcode == OP_STORE);
    assign o_cmd  = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_wp[k]  <= '0;
                r_rp[k]  <= '0;
                r_cnt[k] <= '0;
            end
        end else if (w_accept) begin
            unique case (i_in_data.opcode)
                OP_FLUSH: begin
                    for (int k = 0; k < 2; k++) begin
                        r_wp[k]  <= '0;
                        r_rp[k]  <= '0;
                        r_cnt[k] <= '0;
                    end
                end
                OP_STORE: begin
                    r_wp[w_ch] <= n_wp;
                    // After a drain the ring is empty: head meets tail
                    r_rp[w_ch]  <= w_drain ? n_wp : w_rp_start;
                    r_cnt[w_ch] <= w_drain ? '0 : w_cnt_inc;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### src/dsbb_back.sv
// Back end: owns the sample memory, writes stored samples and drains blocks
// to the output register, a sample per cycle unless stalled. Uses dsbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsbb_back #(
    parameter  int RING_DEPTH  = dsbb_pkg::RING_DEPTH_DEF,
    parameter  int SAMPLE_BITS = dsbb_pkg::SAMPLE_BITS_DEF,
    localparam int PTR_W       = $clog2(RING_DEPTH),
    localparam int CNT_W       = $clog2(RING_DEPTH + 1),
    localparam int CMD_W       = 2 + 2 * PTR_W + SAMPLE_BITS + CNT_W
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [CMD_W-1:0]     i_cmd,
    input  wire dsbb_pkg::t_q_status  i_q_status,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output dsbb_pkg::t_out            o_out_data
);
    import dsbb_pkg::*;

    typedef struct packed {
        logic                   ch;
        logic [PTR_W-1:0]       wptr;
        logic [SAMPLE_BITS-1:0] data;
        logic                   drain;
        logic [PTR_W-1:0]       rptr;
        logic [CNT_W-1:0]       len;
    } t_cmd;

    localparam int MEM_DEPTH = 2 << PTR_W;

    t_cmd                   w_cmd;
    t_back_state            r_state;
    t_back_state            n_state;
    logic                   w_load;
    logic                   w_out_free;

    logic [SAMPLE_BITS-1:0] r_mem [MEM_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    logic                   r_ch;
    logic [PTR_W-1:0]       r_rp;
    logic [CNT_W-1:0]       r_left;
    logic [CNT_W-1:0]       r_len;
    logic                   r_out_valid;
    logic                   r_out_ch;
    logic [LEN_W-1:0]       r_out_len;
    logic                   r_out_last;

    logic                   n_out_valid;
    logic [PTR_W-1:0]       n_rp;

    assign w_cmd      = i_cmd;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign n_rp       = (r_rp == PTR_W'(RING_DEPTH - 1)) ? '0 : r_rp + 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty && w_cmd.drain) begin
                    n_state = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (w_out_free && (r_left == CNT_W'(1))) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        unique case (r_state)
            BK_IDLE:  o_pop  = !i_q_status.empty;
            BK_DRAIN: w_load = w_out_free;
            default: begin
            end
        endcase
    end

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (o_pop && w_cmd.drain) begin
                r_left <= w_cmd.len;
            end else if (w_load) begin
                r_left <= r_left - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_cmd.drain) begin
            r_ch  <= w_cmd.ch;
            r_rp  <= w_cmd.rptr;
            r_len <= w_cmd.len;
        end else if (w_load) begin
            r_rp <= n_rp;
        end
        if (w_load) begin
            r_out_ch   <= r_ch;
            r_out_len  <= LEN_W'(r_len);
            r_out_last <= (r_left == CNT_W'(1));
        end
    end

    // Sample memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mem[{w_cmd.ch, w_cmd.wptr}] <= w_cmd.data;
        end
        if (w_load) begin
            r_rd_data <= r_mem[{r_ch, r_rp}];
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_out_data.out_channel  = r_out_ch;
    assign o_out_data.out_sample   = VALUE_W'(r_rd_data);
    assign o_out_data.block_length = r_out_len;
    assign o_out_data.last         = r_out_last;

endmodule

`default_nettype wire

### src/dual_sample_block_buffer_top.sv
// Top level of the dual sample block buffer: config registers, front end,
// command queue and back end. Depends on dsbb_pkg, dsbb_front, dsbb_queue, dsbb_back.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+-----------------------
//  in       | input     | i_in_valid / o_in_stall    | i_in_data   (t_in)
//  out      | output    | o_out_valid / i_out_stall  | o_out_data  (t_out)
//  cfg      | input     | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// The front end takes one transaction per cycle while the 4-entry command
// queue has room. The back end pops each store and writes its sample to the
// memory; a drain of n samples then follows, one sample per cycle while the
// output is not stalled, through the single read port of the sample memory.
// The back end pops no new command while it drains. Flushes are handled in
// the front end and never enter the queue.
// Reset is synchronous and active low; it clears pointers, counts, queue and
// config registers. Sample memory contents are not reset.
// Output stalls hold the output register and back the queue up; the input
// stall rises only when the queue is full.

module dual_sample_block_buffer_top #(
    parameter int RING_DEPTH  = dsbb_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = dsbb_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration write port
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [dsbb_pkg::LEN_W-1:0]  i_cfg_data,
    // input transactions
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire dsbb_pkg::t_in               i_in_data,
    // output transactions
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output dsbb_pkg::t_out                   o_out_data
);
    import dsbb_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    // command: channel, write pointer, sample, drain flag, read pointer, length
    localparam int CMD_W = 2 + 2 * PTR_W + SAMPLE_BITS + CNT_W;

    // Config registers; the user writes them only while the block is idle, unchecked
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.notify_enable <= 1'b0;
            r_cfg.block_size    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NOTIFY_ENABLE: r_cfg.notify_enable <= i_cfg_data[0];
                CFG_BLOCK_SIZE:    r_cfg.block_size    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic             w_push;
    logic             w_pop;
    logic [CMD_W-1:0] w_push_cmd;
    logic [CMD_W-1:0] w_pop_cmd;
    t_q_status        w_q_status;

    // Front end: bookkeeping of both rings, one command per store
    dsbb_front #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd),
        .i_q_status (w_q_status)
    );

    // Decouples the front end from output stalls
    dsbb_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_cmd),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_cmd),
        .o_status    (w_q_status)
    );

    // Back end: memory writes and block drains, in command order
    dsbb_back #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_pop_cmd),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Never push into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_status.full))
        else $error("command pushed into a full queue");

    // Queue status flags stay consistent
    a_q_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue reports full and empty at once");

    // A delivered sample always belongs to a non-empty block
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.block_length != '0))
        else $error("output with zero block length");

    // Pops only happen with something in the queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("command popped from an empty queue");

endmodule

`default_nettype wire

### tb/tb_dual_sample_block_buffer_top.sv
// Self-checking testbench for dual_sample_block_buffer_top: queued stimulus, a clocked
// driver and monitor, and a cycle-free predictor of the two sample rings.
// Depends on dsbb_pkg and the RTL of the block under test.
`timescale 1ns / 1ps

module tb_dual_sample_block_buffer_top;
    import dsbb_pkg::*;

    localparam int RING_SLOTS   = 64;     // ring depth of the instance
    localparam int QUIET_CYCLES = 24;     // queue (4) + a few stores still in flight
    localparam int CLK_HALF     = 6;
    localparam int TIMEOUT_NS   = 2_000_000;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic               i_cfg_index = CFG_NOTIFY_ENABLE;
    logic [LEN_W-1:0]   i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in                i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out               o_out_data;

    dual_sample_block_buffer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // ------------------------------------------------------------------
    // Testbench copy of the block state
    // ------------------------------------------------------------------
    bit [VALUE_W-1:0] ring_mem [2][RING_SLOTS];
    bit [5:0]         ring_wr [2];
    bit [5:0]         ring_rd [2];
    bit [LEN_W-1:0]   ring_fill [2];
    bit               cfg_notify;
    bit [LEN_W-1:0]   cfg_block_size;

    t_in  items_to_send [$];   // transactions waiting for the driver
    t_out deliveries_due [$];  // predicted output transactions, oldest first

    int items_queued   = 0;
    int items_accepted = 0;
    int error_count    = 0;
    int send_idle_pct  = 0;    // chance that the driver leaves a cycle empty
    int recv_stall_pct = 0;    // chance that the monitor stalls a cycle

    // Applies one accepted transaction to the ring copy; if notify is on, a store
    // bringing its ring to the block size or above queues it as one delivered block.
    function automatic void apply_transaction(t_in tr);
        bit             ch;
        bit [LEN_W-1:0] n;
        t_out           o;
        if (tr.opcode == OP_FLUSH) begin
            for (int k = 0; k < 2; k++) begin
                ring_wr[k]   = '0;
                ring_rd[k]   = '0;
                ring_fill[k] = '0;
            end
            return;
        end
        ch = tr.channel;
        ring_mem[ch][ring_wr[ch]] = tr.sample_value;
        ring_wr[ch] = ring_wr[ch] + 1'b1;
        // full ring: oldest sample is lost, read pointer follows the write
        if (ring_fill[ch] < RING_SLOTS)
            ring_fill[ch] = ring_fill[ch] + 1'b1;
        else
            ring_rd[ch] = ring_rd[ch] + 1'b1;
        if (!cfg_notify || ring_fill[ch] < cfg_block_size)
            return;
        n = ring_fill[ch];
        for (int k = 0; k < n; k++) begin
            o.out_channel  = ch;
            o.out_sample   = ring_mem[ch][ring_rd[ch]];
            o.block_length = n;
            o.last         = (k == n - 1);
            deliveries_due.push_back(o);
            ring_rd[ch] = ring_rd[ch] + 1'b1;
        end
        ring_fill[ch] = '0;
    endfunction

    // ------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: a new transaction is offered only once the previous one is taken,
    // so the idle decision never looks at the stall. A stalled payload is held.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) begin
                apply_transaction(i_in_data);
                items_accepted++;
            end
            if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= items_to_send.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted output transaction against the oldest
    // prediction, then picks the stall for the next cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out exp_o;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (deliveries_due.size() == 0) begin
                    $error("unexpected output transaction: ch %0d sample %0h",
                           o_out_data.out_channel, o_out_data.out_sample);
                    error_count++;
                end else begin
                    exp_o = deliveries_due.pop_front();
                    if (o_out_data.out_channel !== exp_o.out_channel) begin
                        $error("out_channel: expected %0h, got %0h",
                               exp_o.out_channel, o_out_data.out_channel);
                        error_count++;
                    end
                    if (o_out_data.out_sample !== exp_o.out_sample) begin
                        $error("out_sample: expected %0h, got %0h",
                               exp_o.out_sample, o_out_data.out_sample);
                        error_count++;
                    end
                    if (o_out_data.block_length !== exp_o.block_length) begin
                        $error("block_length: expected %0h, got %0h",
                               exp_o.block_length, o_out_data.block_length);
                        error_count++;
                    end
                    if (o_out_data.last !== exp_o.last) begin
                        $error("last: expected %0h, got %0h",
                               exp_o.last, o_out_data.last);
                        error_count++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(logic op, logic ch, logic [VALUE_W-1:0] val);
        t_in tr;
        tr.opcode       = op;
        tr.channel      = ch;
        tr.sample_value = val;
        items_to_send.push_back(tr);
        items_queued++;
    endtask

    // Mostly stores so that rings fill up to the block size; rare flushes.
    task automatic push_random(int count);
        logic [VALUE_W-1:0] val;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(7))
                0:       val = '0;
                1:       val = '1;
                default: val = VALUE_W'($urandom);
            endcase
            if ($urandom_range(99) < 3)
                push_item(OP_FLUSH, 1'($urandom), val);
            else
                push_item(OP_STORE, 1'($urandom), val);
        end
    endtask

    // Block is idle once every transaction is taken, every block has been
    // delivered and the stores without a result have left the queue.
    task automatic wait_idle();
        while (items_accepted != items_queued || deliveries_due.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers on consecutive edges; only called while idle.
    task automatic write_regs(bit ne, bit [LEN_W-1:0] bs);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_NOTIFY_ENABLE;
        i_cfg_data  <= LEN_W'(ne);
        @(posedge i_clk);
        i_cfg_index <= CFG_BLOCK_SIZE;
        i_cfg_data  <= bs;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_notify     = ne;
        cfg_block_size = bs;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero block size: every store is delivered at once
        set_idling(0, 0);
        write_regs(1'b1, 7'd0);
        push_item(OP_STORE, 1'b0, 16'h0000);
        push_item(OP_STORE, 1'b1, 16'hFFFF);
        push_item(OP_FLUSH, 1'b1, 16'hFFFF);
        wait_idle();

        write_regs(1'b1, 7'd1);
        push_item(OP_STORE, 1'b1, 16'h8001);
        push_item(OP_STORE, 1'b0, 16'h7FFE);
        wait_idle();

        // flush drops a half-filled ring and resets both pointers
        write_regs(1'b1, 7'd2);
        push_item(OP_STORE, 1'b0, 16'hAAAA);
        push_item(OP_STORE, 1'b1, 16'h5555);
        push_item(OP_STORE, 1'b0, 16'hFFFF);
        push_item(OP_FLUSH, 1'b0, 16'h0000);
        push_item(OP_STORE, 1'b1, 16'h1234);
        push_item(OP_STORE, 1'b1, 16'h0001);
        push_item(OP_STORE, 1'b1, 16'hFFFE);
        push_item(OP_FLUSH, 1'b1, 16'h8000);
        wait_idle();

        // delivery off: overfill ring A so the oldest samples get overwritten
        set_idling(51, 0);
        write_regs(1'b0, 7'd64);
        for (int k = 0; k < 70; k++)
            push_item(OP_STORE, 1'b0, VALUE_W'($urandom));
        for (int k = 0; k < 3; k++)
            push_item(OP_STORE, 1'b1, VALUE_W'($urandom));
        wait_idle();

        // largest block: one store on the full ring drains all 64 samples
        set_idling(0, 51);
        write_regs(1'b1, 7'd64);
        push_item(OP_STORE, 1'b0, 16'hC3C3);
        push_item(OP_STORE, 1'b1, 16'h3C3C);
        wait_idle();

        // block size beyond the ring depth: nothing is ever delivered
        set_idling(14, 14);
        write_regs(1'b1, 7'd100);
        push_random(30);
        wait_idle();
        write_regs(1'b1, 7'd127);
        push_random(20);
        wait_idle();

        // lowering the size releases what was buffered above
        set_idling(0, 0);
        write_regs(1'b1, 7'd5);
        push_item(OP_STORE, 1'b1, VALUE_W'($urandom));
        push_random(50);
        wait_idle();

        set_idling(51, 0);
        write_regs(1'b1, 7'd12);
        push_random(40);
        wait_idle();

        set_idling(0, 51);
        write_regs(1'b1, 7'd3);
        push_random(35);
        wait_idle();

        set_idling(14, 14);
        write_regs(1'b1, 7'd7);
        push_random(35);
        wait_idle();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
src/dsbb_pkg.sv
src/dsbb_queue.sv
src/dsbb_front.sv
src/dsbb_back.sv
src/dual_sample_block_buffer_top.sv
tb/tb_dual_sample_block_buffer_top.sv
